// File: rtl/core/stack_push_pop_unit_macros.svh
// Assertion macros for the stack push/pop unit.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef STACK_PUSH_POP_UNIT_MACROS_SVH
`define STACK_PUSH_POP_UNIT_MACROS_SVH

// Same-cycle implication.
`define SPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spu same-cycle check failed");

// Next-cycle implication.
`define SPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spu next-cycle check failed");

`endif

// File: rtl/core/spu_pkg.sv
// Shared types, constants and decode functions of the stack push/pop unit.
// No dependencies; every other source file but the assertion macros imports it.
package spu_pkg;

  localparam int unsigned MEM_ADDR_BITS = 12;
  localparam int unsigned MEM_DEPTH     = 1 << MEM_ADDR_BITS;
  localparam int unsigned NUM_SLOTS     = 6;
  localparam int unsigned SLOT_BITS     = 3;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam logic [15:0] SEG_MASK      = 16'h000F;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODEL_U8     = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LARGE_MEMORY = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PUSH      = 2'd0,
    FUNC_POP       = 2'd1,
    FUNC_PUSH_LIST = 2'd2,
    FUNC_POP_LIST  = 2'd3
  } func_e;

  // Register selected by a byte access; PC/CSR/PSW mean ELR/ECSR/EPSW on a push.
  typedef enum logic [2:0] {
    SEL_OPER = 3'd0,
    SEL_EA   = 3'd1,
    SEL_LR   = 3'd2,
    SEL_LCSR = 3'd3,
    SEL_PSW  = 3'd4,
    SEL_PC   = 3'd5,
    SEL_CSR  = 3'd6
  } reg_sel_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  operand_size;
    logic [63:0] push_data;
    logic [3:0]  reg_mask;
    logic [15:0] ea_value;
    logic [15:0] lr_value;
    logic [3:0]  lcsr_value;
    logic [15:0] elr_value;
    logic [3:0]  ecsr_value;
    logic [15:0] epsw_value;
  } spu_in_t;

  typedef struct packed {
    logic [63:0] pop_data;
    logic [15:0] ea_out;
    logic [15:0] lr_out;
    logic [3:0]  lcsr_out;
    logic [15:0] psw_out;
    logic [15:0] pc_out;
    logic [3:0]  csr_out;
    logic [3:0]  loaded_mask;
    logic [15:0] sp_out;
    logic [3:0]  cycles;
  } spu_out_t;

  typedef struct packed {
    logic       load;
    logic [3:0] cycles;
    logic       mem_we;
    logic       mem_re;
    reg_sel_e   sel;
    logic [2:0] idx;
    logic [4:0] off;       // two's complement address offset from SP
    logic [4:0] sp_delta;  // two's complement SP adjustment
    logic       publish;
  } spu_cmd_t;

  typedef struct packed {
    logic cap_pending;
  } spu_stat_t;

  function automatic logic [3:0] decode_size(logic [3:0] s);
    logic [3:0] r;
    if (s <= 4'd1) r = 4'd1;
    else if (s == 4'd2) r = 4'd2;
    else if (s <= 4'd4) r = 4'd4;
    else r = 4'd8;
    return r;
  endfunction

  // Word order of a list operation; bit 0 goes first.
  function automatic logic [NUM_SLOTS-1:0] list_slots(logic is_pop, logic [3:0] mask,
                                                      logic large_mem);
    logic [NUM_SLOTS-1:0] s;
    if (is_pop) begin
      s = {mask[1] & large_mem, mask[1], mask[2], mask[3] & large_mem, mask[3], mask[0]};
    end else begin
      s = {mask[0], mask[3], mask[3] & large_mem, mask[2], mask[1], mask[1] & large_mem};
    end
    return s;
  endfunction

  function automatic reg_sel_e slot_sel(logic is_pop, logic [SLOT_BITS-1:0] slot);
    reg_sel_e r;
    case (slot)
      3'd0:    r = is_pop ? SEL_EA   : SEL_CSR;
      3'd1:    r = is_pop ? SEL_LR   : SEL_PC;
      3'd2:    r = is_pop ? SEL_LCSR : SEL_PSW;
      3'd3:    r = is_pop ? SEL_PSW  : SEL_LCSR;
      3'd4:    r = is_pop ? SEL_PC   : SEL_LR;
      3'd5:    r = is_pop ? SEL_CSR  : SEL_EA;
      default: r = SEL_OPER;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] list_cost(logic is_pop, logic [3:0] mask, logic u8,
                                           logic large_mem);
    logic [4:0] c;
    logic [4:0] unit;
    unit = u8 ? 5'd2 : 5'd1;
    c    = '0;
    if (is_pop) begin
      if (mask[0])              c = c + (u8 ? 5'd4 : 5'd2);
      if (mask[3])              c = c + unit;
      if (mask[3] && large_mem) c = c + unit;
      if (mask[2])              c = c + unit;
      if (mask[1])              c = c + (u8 ? 5'd4 : 5'd3);
      if (mask[1] && large_mem) c = c + 5'd1;
    end else begin
      if (mask[1])              c = c + unit;
      if (mask[1] && large_mem) c = c + unit;
      if (mask[2])              c = c + unit;
      if (mask[3])              c = c + unit;
      if (mask[3] && large_mem) c = c + unit;
      if (mask[0])              c = c + unit;
    end
    return c[3:0];
  endfunction

endpackage

// File: rtl/core/spu_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on spu_pkg for the payload structs.
interface spu_in_if import spu_pkg::*; ();
  logic    valid;
  logic    ready;
  spu_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface spu_out_if import spu_pkg::*; ();
  logic     valid;
  logic     ready;
  spu_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/stack_push_pop_unit.sv
// Stack push/pop unit top level: wires the sequencer to the datapath.
// Depends on spu_pkg, spu_if, spu_ctrl, spu_dp and the assertion macros.
//
// Usage: one instruction beat enters on in_i (func, operand size, push data,
// register mask and current register values); exactly one result beat leaves
// on out_o (popped data, restored registers, loaded mask, new SP, cycle cost).
// Settings are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle:
// index 0 selects nX-U8 costs, index 1 large memory mode.
// Operand pushes and pops move 1, 2, 4 or 8 bytes; list pushes and pops
// move up to 6 words, and an empty list makes no memory access. The single
// byte port of the stack memory takes one access per cycle. One instruction
// is in flight at a time, and the next is taken the cycle after its result
// is registered.
// Reset: SP is 0, nX-U8 costs, small memory mode; memory contents are
// undefined and no clearing pass runs. A stalled receiver holds the result
// in the output register; a new instruction is still accepted and executed,
// and its result waits until the previous beat is taken.
`include "stack_push_pop_unit_macros.svh"

module stack_push_pop_unit import spu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  spu_in_if.sink                  in_i,
  spu_out_if.source               out_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic                    cfg_wdata_i
);

  spu_cmd_t  cmd;
  spu_stat_t stat;

  spu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.payload.func),
    .in_size_i   (in_i.payload.operand_size),
    .in_mask_i   (in_i.payload.reg_mask),
    .out_ready_i (out_o.ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid)
  );

  spu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_i.payload),
    .stat_o     (stat),
    .out_data_o (out_o.payload)
  );

  `SPU_ASSERT_NOW(a_no_rw_same_cycle, cmd.mem_we, !cmd.mem_re)
  `SPU_ASSERT_NOW(a_publish_after_capture, cmd.publish, !stat.cap_pending)
  `SPU_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready)
  `SPU_ASSERT_NEXT(a_publish_sets_valid, cmd.publish, out_o.valid)

endmodule

// File: rtl/core/spu_dp.sv
// Datapath: stack pointer, byte stack memory, operand latch, result assembly.
// Depends on spu_pkg; driven by commands from spu_ctrl.
module spu_dp import spu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  spu_cmd_t  cmd_i,
  input  spu_in_t   in_data_i,
  output spu_stat_t stat_o,
  output spu_out_t  out_data_o
);

  logic [7:0] mem_q [MEM_DEPTH];
  logic [7:0] rdata_q;

  spu_in_t    in_q;
  logic [15:0] sp_q;
  logic        cap_vld_q;
  reg_sel_e    cap_sel_q;
  logic [2:0]  cap_idx_q;

  logic [63:0] pop_q;
  logic [15:0] ea_q, lr_q, psw_q, pc_q;
  logic [3:0]  lcsr_q, csr_q, loaded_q, cycles_q;
  spu_out_t    out_q;

  logic [15:0]              word;
  logic [7:0]               wdata;
  logic [15:0]              addr_sum;
  logic [MEM_ADDR_BITS-1:0] mem_addr;
  logic [7:0]               seg_byte;

  assign addr_sum = sp_q + {{11{cmd_i.off[4]}}, cmd_i.off};
  assign mem_addr = addr_sum[MEM_ADDR_BITS-1:0];
  assign seg_byte = rdata_q & SEG_MASK[7:0];

  always_comb begin
    case (cmd_i.sel)
      SEL_EA:   word = in_q.ea_value;
      SEL_LR:   word = in_q.lr_value;
      SEL_LCSR: word = {12'h000, in_q.lcsr_value};
      SEL_PSW:  word = in_q.epsw_value;
      SEL_PC:   word = in_q.elr_value;
      SEL_CSR:  word = {12'h000, in_q.ecsr_value};
      default:  word = '0;
    endcase
    if (cmd_i.sel == SEL_OPER) begin
      wdata = in_q.push_data[{cmd_i.idx, 3'b000} +: 8];
    end else begin
      wdata = cmd_i.idx[0] ? word[15:8] : word[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[mem_addr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      cap_vld_q <= 1'b0;
    end else begin
      sp_q      <= sp_q + {{11{cmd_i.sp_delta[4]}}, cmd_i.sp_delta};
      cap_vld_q <= cmd_i.mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_sel_q <= cmd_i.sel;
    cap_idx_q <= cmd_i.idx;
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
  end

  // Clear results on load; drop each read byte from rdata_q into its register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pop_q    <= '0;
      ea_q     <= '0;
      lr_q     <= '0;
      lcsr_q   <= '0;
      psw_q    <= '0;
      pc_q     <= '0;
      csr_q    <= '0;
      loaded_q <= (in_data_i.func == FUNC_POP_LIST) ? in_data_i.reg_mask : 4'h0;
      cycles_q <= cmd_i.cycles;
    end else if (cap_vld_q) begin
      case (cap_sel_q)
        SEL_OPER: pop_q[{cap_idx_q, 3'b000} +: 8] <= rdata_q;
        SEL_EA:   if (cap_idx_q[0]) ea_q[15:8] <= rdata_q; else ea_q[7:0] <= rdata_q;
        SEL_LR:   if (cap_idx_q[0]) lr_q[15:8] <= rdata_q; else lr_q[7:0] <= rdata_q;
        SEL_PSW:  if (cap_idx_q[0]) psw_q[15:8] <= rdata_q; else psw_q[7:0] <= rdata_q;
        SEL_PC:   if (cap_idx_q[0]) pc_q[15:8] <= rdata_q; else pc_q[7:0] <= rdata_q;
        SEL_LCSR: if (!cap_idx_q[0]) lcsr_q <= seg_byte[3:0];
        SEL_CSR:  if (!cap_idx_q[0]) csr_q <= seg_byte[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.pop_data    <= pop_q;
      out_q.ea_out      <= ea_q;
      out_q.lr_out      <= lr_q;
      out_q.lcsr_out    <= lcsr_q;
      out_q.psw_out     <= psw_q;
      out_q.pc_out      <= pc_q;
      out_q.csr_out     <= csr_q;
      out_q.loaded_mask <= loaded_q;
      out_q.sp_out      <= sp_q;
      out_q.cycles      <= cycles_q;
    end
  end

  assign stat_o.cap_pending = cap_vld_q;
  assign out_data_o         = out_q;

endmodule

// File: rtl/core/spu_ctrl.sv
// Controller: configuration registers, instruction sequencer, result handshake.
// Depends on spu_pkg; issues one byte access per cycle to spu_dp while running.
module spu_ctrl import spu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [1:0]              in_func_i,
  input  logic [3:0]              in_size_i,
  input  logic [3:0]              in_mask_i,
  input  logic                    out_ready_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic                    cfg_wdata_i,
  input  spu_stat_t               stat_i,
  output spu_cmd_t                cmd_o,
  output logic                    in_ready_o,
  output logic                    out_valid_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [1:0]           func_q, func_d;
  logic [3:0]           size_q, size_d;
  logic [NUM_SLOTS-1:0] slots_q, slots_d;
  logic [2:0]           bcnt_q, bcnt_d;
  logic                 half_q, half_d;
  logic                 out_valid_q, out_valid_d;
  logic                 model_u8_q, large_q;

  logic                 accept;
  logic                 is_list;
  logic                 is_pop_list;
  logic [3:0]           step;
  logic [SLOT_BITS-1:0] cur_slot;
  logic [NUM_SLOTS-1:0] slots_left;
  logic                 last_byte;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_list     = (in_func_i == FUNC_PUSH_LIST) || (in_func_i == FUNC_POP_LIST);
  assign is_pop_list = (func_q == FUNC_POP_LIST);
  assign step        = (size_q == 4'd1) ? 4'd2 : size_q;
  assign slots_left  = slots_q & (slots_q - {{(NUM_SLOTS-1){1'b0}}, 1'b1});
  assign last_byte   = ({1'b0, bcnt_q} == (size_q - 4'd1));

  always_comb begin
    cur_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slots_q[i]) cur_slot = SLOT_BITS'(i);
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    func_d  = func_q;
    size_d  = size_q;
    slots_d = slots_q;
    bcnt_d  = bcnt_q;
    half_d  = half_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load   = 1'b1;
          cmd_o.cycles = is_list ?
            list_cost(in_func_i == FUNC_POP_LIST, in_mask_i, model_u8_q, large_q) : 4'h0;
          func_d  = in_func_i;
          size_d  = decode_size(in_size_i);
          slots_d = is_list ? list_slots(in_func_i == FUNC_POP_LIST, in_mask_i, large_q) : '0;
          bcnt_d  = '0;
          half_d  = 1'b0;
          if (is_list && (list_slots(in_func_i == FUNC_POP_LIST, in_mask_i, large_q) == '0))
          begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if ((func_q == FUNC_PUSH) || (func_q == FUNC_POP)) begin
          cmd_o.sel = SEL_OPER;
          cmd_o.idx = bcnt_q;
          if (func_q == FUNC_PUSH) begin
            // Bytes land below the current SP; SP moves on the last byte.
            cmd_o.mem_we = 1'b1;
            cmd_o.off    = {2'b00, bcnt_q} - {1'b0, step};
          end else begin
            cmd_o.mem_re = 1'b1;
            cmd_o.off    = {2'b00, bcnt_q};
          end
          if (last_byte) begin
            cmd_o.sp_delta = (func_q == FUNC_PUSH) ? (5'd0 - {1'b0, step}) : {1'b0, step};
            state_d        = ST_FIN;
          end else begin
            bcnt_d = bcnt_q + 3'd1;
          end
        end else begin
          cmd_o.sel = slot_sel(is_pop_list, cur_slot);
          cmd_o.idx = {2'b00, half_q};
          if (is_pop_list) begin
            cmd_o.mem_re = 1'b1;
            cmd_o.off    = {4'b0000, half_q};
          end else begin
            cmd_o.mem_we = 1'b1;
            cmd_o.off    = 5'd0 - 5'd2 + {4'b0000, half_q};
          end
          if (half_q) begin
            cmd_o.sp_delta = is_pop_list ? 5'd2 : (5'd0 - 5'd2);
            slots_d        = slots_left;
            half_d         = 1'b0;
            if (slots_left == '0) state_d = ST_FIN;
          end else begin
            half_d = 1'b1;
          end
        end
      end
      ST_FIN: begin
        // Hold until the last read byte is in and the output register is free.
        if (!stat_i.cap_pending && (!out_valid_q || out_ready_i)) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.publish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      func_q      <= '0;
      size_q      <= 4'd1;
      slots_q     <= '0;
      bcnt_q      <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      model_u8_q  <= 1'b1;
      large_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      func_q      <= func_d;
      size_q      <= size_d;
      slots_q     <= slots_d;
      bcnt_q      <= bcnt_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODEL_U8:     model_u8_q <= cfg_wdata_i;
          CFG_LARGE_MEMORY: large_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/sv/spu_tb_pkg.sv
// Helpers for the stack push/pop unit testbench: operand size decode, list
// word count and the stack memory slot of an address. Depends on spu_pkg.
package spu_tb_pkg;
  import spu_pkg::*;

  // Bytes moved by an operand of the given size code.
  function automatic int unsigned operand_bytes(logic [3:0] code);
    int unsigned n;
    if (code <= 4'd1) n = 1;
    else if (code == 4'd2) n = 2;
    else if (code <= 4'd4) n = 4;
    else n = 8;
    return n;
  endfunction

  // 16-bit words moved by a register-list push or pop.
  function automatic int unsigned list_words(logic [3:0] mask, logic large_mem);
    int unsigned n;
    n = 0;
    if (mask[0]) n++;
    if (mask[2]) n++;
    if (mask[1]) n += large_mem ? 2 : 1;
    if (mask[3]) n += large_mem ? 2 : 1;
    return n;
  endfunction

  function automatic logic [MEM_ADDR_BITS-1:0] stack_slot(logic [15:0] addr);
    return addr[MEM_ADDR_BITS-1:0];
  endfunction

endpackage

// File: tb/sv/spu_result_checker.sv
// Passive checker of the stack push/pop unit: mirrors SP, stack memory and
// settings, predicts each result beat and compares it. Depends on spu_pkg,
// spu_tb_pkg and the spu_in_if/spu_out_if channel interfaces.
module spu_result_checker import spu_pkg::*, spu_tb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  spu_in_if                       in_i,
  spu_out_if                      res_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic                    cfg_wdata_i,
  output logic                    busy_o,
  output int                      errors_o,
  output int                      checked_o
);

  logic [7:0]  stk_mem [MEM_DEPTH];
  logic [15:0] stk_sp;
  logic        cfg_u8;
  logic        cfg_large;
  spu_out_t    pending_q [$];
  spu_out_t    want;
  spu_out_t    got;

  task automatic push_word(input logic [15:0] v);
    stk_sp = stk_sp - 16'd2;
    stk_mem[stack_slot(stk_sp + 16'd1)] = v[15:8];
    stk_mem[stack_slot(stk_sp)] = v[7:0];
  endtask

  task automatic pop_word(output logic [15:0] v);
    v = {stk_mem[stack_slot(stk_sp + 16'd1)], stk_mem[stack_slot(stk_sp)]};
    stk_sp = stk_sp + 16'd2;
  endtask

  // Run one instruction on the mirrored stack and build its result beat.
  task automatic execute(input spu_in_t op, output spu_out_t r);
    int unsigned nbytes;
    logic [15:0] stride;
    logic [4:0]  unit;
    logic [4:0]  cost;
    logic [15:0] w;
    r      = '0;
    cost   = '0;
    unit   = cfg_u8 ? 5'd2 : 5'd1;
    nbytes = operand_bytes(op.operand_size);
    stride = (nbytes == 1) ? 16'd2 : 16'(nbytes);
    case (func_e'(op.func))
      FUNC_PUSH: begin
        stk_sp = stk_sp - stride;
        for (int unsigned i = 0; i < nbytes; i++) begin
          stk_mem[stack_slot(stk_sp + 16'(i))] = op.push_data[8*i +: 8];
        end
      end
      FUNC_POP: begin
        for (int unsigned i = 0; i < nbytes; i++) begin
          r.pop_data[8*i +: 8] = stk_mem[stack_slot(stk_sp + 16'(i))];
        end
        stk_sp = stk_sp + stride;
      end
      FUNC_PUSH_LIST: begin
        if (op.reg_mask[1]) begin
          cost = cost + unit;
          if (cfg_large) begin
            cost = cost + unit;
            push_word({12'd0, op.ecsr_value});
          end
          push_word(op.elr_value);
        end
        if (op.reg_mask[2]) begin
          cost = cost + unit;
          push_word(op.epsw_value);
        end
        if (op.reg_mask[3]) begin
          cost = cost + unit;
          if (cfg_large) begin
            cost = cost + unit;
            push_word({12'd0, op.lcsr_value});
          end
          push_word(op.lr_value);
        end
        if (op.reg_mask[0]) begin
          cost = cost + unit;
          push_word(op.ea_value);
        end
      end
      default: begin
        r.loaded_mask = op.reg_mask;
        if (op.reg_mask[0]) begin
          cost = cost + (cfg_u8 ? 5'd4 : 5'd2);
          pop_word(w);
          r.ea_out = w;
        end
        if (op.reg_mask[3]) begin
          cost = cost + unit;
          pop_word(w);
          r.lr_out = w;
          if (cfg_large) begin
            cost = cost + unit;
            pop_word(w);
            r.lcsr_out = w[3:0];
          end
        end
        if (op.reg_mask[2]) begin
          cost = cost + unit;
          pop_word(w);
          r.psw_out = w;
        end
        if (op.reg_mask[1]) begin
          cost = cost + (cfg_u8 ? 5'd4 : 5'd3);
          pop_word(w);
          r.pc_out = w;
          if (cfg_large) begin
            cost = cost + 5'd1;
            pop_word(w);
            r.csr_out = w[3:0];
          end
        end
      end
    endcase
    r.sp_out = stk_sp;
    r.cycles = cost[3:0];
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_sp    = '0;
      cfg_u8    = 1'b1;
      cfg_large = 1'b0;
      pending_q.delete();
      errors_o  = 0;
      checked_o = 0;
      busy_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MODEL_U8) cfg_u8 = cfg_wdata_i;
        else if (cfg_idx_i == CFG_LARGE_MEMORY) cfg_large = cfg_wdata_i;
      end
      // Take the input beat first so a same-edge result still meets the oldest entry.
      if (in_i.valid && in_i.ready) begin
        execute(in_i.payload, want);
        pending_q.push_back(want);
      end
      if (res_i.valid && res_i.ready) begin
        got = res_i.payload;
        if (pending_q.size() == 0) begin
          $error("result beat with no instruction pending, sp_out %h", got.sp_out);
          errors_o++;
        end else begin
          want = pending_q.pop_front();
          checked_o++;
          check_field("pop_data", want.pop_data, got.pop_data);
          check_field("ea_out", 64'(want.ea_out), 64'(got.ea_out));
          check_field("lr_out", 64'(want.lr_out), 64'(got.lr_out));
          check_field("lcsr_out", 64'(want.lcsr_out), 64'(got.lcsr_out));
          check_field("psw_out", 64'(want.psw_out), 64'(got.psw_out));
          check_field("pc_out", 64'(want.pc_out), 64'(got.pc_out));
          check_field("csr_out", 64'(want.csr_out), 64'(got.csr_out));
          check_field("loaded_mask", 64'(want.loaded_mask), 64'(got.loaded_mask));
          check_field("sp_out", 64'(want.sp_out), 64'(got.sp_out));
          check_field("cycles", 64'(want.cycles), 64'(got.cycles));
        end
      end
      busy_o <= (pending_q.size() != 0);
    end
  end

endmodule

// File: tb/sv/tb_stack_push_pop_unit.sv
// Top of the stack push/pop unit testbench: clock, reset, instruction and
// settings stimulus, result back-pressure and the verdict. Depends on spu_pkg,
// spu_tb_pkg, spu_if, spu_result_checker and the unit itself.
module tb_stack_push_pop_unit;
  import spu_pkg::*;
  import spu_tb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_TAIL  = 20;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic                    cfg_wdata;
  logic                    busy;
  int                      errors;
  int                      checked;

  spu_in_if  in_bus ();
  spu_out_if out_bus ();

  stack_push_pop_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  spu_result_checker u_result_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .res_i      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .busy_o     (busy),
    .errors_o   (errors),
    .checked_o  (checked)
  );

  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  logic [15:0] gen_sp;
  logic        gen_large;
  bit          mem_written [MEM_DEPTH];
  int          issued;
  int          func_count [4];
  int          n_settings;
  int          stuck;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit readable(logic [15:0] base, int unsigned n);
    bit ok;
    ok = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (!mem_written[stack_slot(base + 16'(i))]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void mark_written(logic [15:0] base, int unsigned n);
    for (int unsigned i = 0; i < n; i++) mem_written[stack_slot(base + 16'(i))] = 1'b1;
  endfunction

  function automatic spu_in_t random_op();
    spu_in_t op;
    op.func         = 2'($urandom_range(3));
    op.operand_size = $urandom_range(1) ? 4'(1 << $urandom_range(3))
                                        : 4'($urandom_range(15));
    op.push_data    = {$urandom, $urandom};
    op.reg_mask     = 4'($urandom_range(15));
    op.ea_value     = 16'($urandom);
    op.lr_value     = 16'($urandom);
    op.lcsr_value   = 4'($urandom);
    op.elr_value    = 16'($urandom);
    op.ecsr_value   = 4'($urandom);
    op.epsw_value   = 16'($urandom);
    return op;
  endfunction

  function automatic spu_in_t mk(func_e f, logic [3:0] sz, logic [63:0] d, logic [3:0] m,
                                 logic [15:0] rv);
    spu_in_t op;
    op = '{func: f, operand_size: sz, push_data: d, reg_mask: m, ea_value: rv,
           lr_value: rv, lcsr_value: rv[3:0], elr_value: rv, ecsr_value: rv[3:0],
           epsw_value: rv};
    return op;
  endfunction

  task automatic send_beat(input spu_in_t it);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_bus.valid   <= 1'b1;
    in_bus.payload <= it;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Track SP and written bytes so no pop ever reads unwritten stack memory.
  task automatic issue(input spu_in_t op);
    spu_in_t     it;
    int unsigned nb;
    int unsigned nw;
    logic [15:0] stride;
    it     = op;
    nb     = operand_bytes(it.operand_size);
    stride = (nb == 1) ? 16'd2 : 16'(nb);
    nw     = 2 * list_words(it.reg_mask, gen_large);
    if (it.func == FUNC_POP && !readable(gen_sp, nb)) it.func = FUNC_PUSH;
    if (it.func == FUNC_POP_LIST && !readable(gen_sp, nw)) it.func = FUNC_PUSH_LIST;
    case (func_e'(it.func))
      FUNC_PUSH: begin
        gen_sp = gen_sp - stride;
        mark_written(gen_sp, nb);
      end
      FUNC_POP: gen_sp = gen_sp + stride;
      FUNC_PUSH_LIST: begin
        gen_sp = gen_sp - 16'(nw);
        mark_written(gen_sp, nw);
      end
      default: gen_sp = gen_sp + 16'(nw);
    endcase
    func_count[it.func]++;
    issued++;
    send_beat(it);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_config(input logic u8, input logic large_mem);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MODEL_U8;
    cfg_wdata <= u8;
    @(posedge clk);
    cfg_idx   <= CFG_LARGE_MEMORY;
    cfg_wdata <= large_mem;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_large = large_mem;
    n_settings++;
  endtask

  task automatic set_mode(input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
  endtask

  task automatic run_directed();
    // Operand extremes, widths and codes 0, 3, 15; SP wraps below zero and back.
    issue(mk(FUNC_PUSH, 4'd8, '1, 4'd0, 16'h0000));
    issue(mk(FUNC_PUSH, 4'd8, '0, 4'd15, 16'hFFFF));
    issue(mk(FUNC_PUSH, 4'd1, 64'hA5, 4'd0, 16'h0000));
    issue(mk(FUNC_PUSH, 4'd2, 64'hBEEF, 4'd0, 16'h0000));
    issue(mk(FUNC_PUSH, 4'd4, 64'h89AB_CDEF, 4'd0, 16'h0000));
    issue(mk(FUNC_PUSH, 4'd0, 64'hFFFF_FFFF_FFFF_FF5A, 4'd0, 16'h0000));
    issue(mk(FUNC_PUSH, 4'd3, 64'h0123_4567, 4'd0, 16'h0000));
    issue(mk(FUNC_PUSH, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd15, '1, 4'd15, 16'hFFFF));
    issue(mk(FUNC_POP, 4'd3, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd0, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd4, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd2, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd1, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd8, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP, 4'd8, '0, 4'd0, 16'h0000));
    // Register lists: full, empty, and a partial one.
    issue(mk(FUNC_PUSH_LIST, 4'd8, '0, 4'd15, 16'hFFFF));
    issue(mk(FUNC_PUSH_LIST, 4'd8, '1, 4'd0, 16'hFFFF));
    issue(mk(FUNC_POP_LIST, 4'd8, '0, 4'd0, 16'h0000));
    issue(mk(FUNC_POP_LIST, 4'd8, '0, 4'd15, 16'h0000));
    issue(mk(FUNC_PUSH_LIST, 4'd8, '0, 4'd15, 16'h0000));
    issue(mk(FUNC_POP_LIST, 4'd8, '1, 4'd15, 16'hFFFF));
    issue(mk(FUNC_PUSH_LIST, 4'd1, '0, 4'd10, 16'h5A3C));
    issue(mk(FUNC_POP_LIST, 4'd1, '0, 4'd10, 16'h0000));
  endtask

  // Write every byte of the stack once so later pops can land anywhere.
  task automatic fill_stack();
    spu_in_t op;
    for (int i = 0; i < MEM_DEPTH / 8; i++) begin
      op              = random_op();
      op.func         = FUNC_PUSH;
      op.operand_size = 4'($urandom_range(5, 15));
      issue(op);
    end
  endtask

  // Push a register list, nest a few operands, unwind them and restore the list.
  task automatic run_frame();
    spu_in_t    op;
    logic [3:0] m;
    logic [3:0] sz [4];
    int         k;
    m = 4'($urandom_range(15));
    k = $urandom_range(3);
    op = random_op();
    op.func = FUNC_PUSH_LIST;
    op.reg_mask = m;
    issue(op);
    for (int i = 0; i < k; i++) begin
      op = random_op();
      op.func = FUNC_PUSH;
      sz[i] = op.operand_size;
      issue(op);
    end
    for (int i = k - 1; i >= 0; i--) begin
      op = random_op();
      op.func = FUNC_POP;
      op.operand_size = sz[i];
      issue(op);
    end
    op = random_op();
    op.func = FUNC_POP_LIST;
    if ($urandom_range(9) != 0) op.reg_mask = m;
    issue(op);
  endtask

  task automatic run_random(input int n);
    int stop;
    int half;
    bit paused;
    stop   = issued + n;
    half   = issued + n / 2;
    paused = 1'b0;
    while (issued < stop) begin
      if (!paused && issued >= half) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 65) run_frame();
      else issue(random_op());
    end
  endtask

  // Result back-pressure, with an occasional long hold-off on request.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) stuck = 0;
      else stuck++;
    end
    $display("stack_push_pop_unit regression: fail");
    $finish;
  end

  initial begin
    in_bus.valid   <= 1'b0;
    in_bus.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_MODEL_U8;
    cfg_wdata      <= 1'b0;
    rst_n          <= 1'b0;
    gen_sp     = '0;
    gen_large  = 1'b0;
    issued     = 0;
    n_settings = 0;
    hold_req   = 1'b0;
    set_mode(0, 0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_mode(35, 73);
    set_config(1'b1, 1'b1);
    run_directed();
    wait_drained();
    set_config(1'b1, 1'b0);
    fill_stack();
    run_random(150);
    wait_drained();
    set_config(1'b0, 1'b1);
    run_random(300);

    wait_drained();
    set_mode(73, 35);
    set_config(1'b0, 1'b0);
    run_random(320);
    wait_drained();
    set_config(1'b1, 1'b1);
    run_random(320);

    wait_drained();
    set_mode(0, 0);
    set_config(1'b0, 1'b1);
    hold_req = 1'b1;
    run_random(320);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("covered %0d beats: %0d push, %0d pop, %0d list push, %0d list pop",
             issued, func_count[FUNC_PUSH], func_count[FUNC_POP],
             func_count[FUNC_PUSH_LIST], func_count[FUNC_POP_LIST]);
    $display("  %0d settings of cost model and memory mode, full-stack fill, %0d results checked",
             n_settings, checked);
    if (errors == 0 && !busy) begin
      $display("stack_push_pop_unit regression: pass");
    end else begin
      $display("stack_push_pop_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: stack_push_pop_unit.f
+incdir+rtl/core
rtl/core/spu_pkg.sv
rtl/core/spu_if.sv
rtl/core/spu_dp.sv
rtl/core/spu_ctrl.sv
rtl/core/stack_push_pop_unit.sv
tb/sv/spu_tb_pkg.sv
tb/sv/spu_result_checker.sv
tb/sv/tb_stack_push_pop_unit.sv
